>>> sv/tic_pkg.sv
// Shared types and constants for the timer and interrupt controller.
// Used by tic_timer, tic_irq and timer_interrupt_controller_top.
package tic_pkg;

  localparam int unsigned CyclesW  = 6;
  localparam int unsigned PeriodW  = 11;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned VectorW  = 7;
  localparam int unsigned DivAccW  = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned ServeN   = 5;
  localparam int unsigned TimerIrqBit = 2;

  localparam logic [DivAccW-1:0] DivLimit     = 9'd255;
  localparam logic [PeriodW-1:0] PeriodReset  = 11'd1024;
  localparam logic [ByteW-1:0]   CounterTop   = 8'hFF;
  localparam logic [VectorW-1:0] VectorBase   = 7'h40;
  localparam logic [1:0]         CountdownArm = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMER_ENABLE   = 2'd0,
    REG_TIMER_PERIOD   = 2'd1,
    REG_RELOAD_VALUE   = 2'd2,
    REG_INTERRUPT_MASK = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CyclesW-1:0] cycles;
    logic               disable_request;
    logic               enable_request;
    logic [ByteW-1:0]   irq_requests;
  } in_t;

  typedef struct packed {
    logic               take_interrupt;
    logic [VectorW-1:0] vector;
    logic [ByteW-1:0]   counter_value;
    logic [ByteW-1:0]   divider_value;
    logic [ByteW-1:0]   interrupt_flags;
    logic               master_enable;
  } out_t;

  typedef struct packed {
    logic               timer_enable;
    logic [PeriodW-1:0] timer_period;
    logic [ByteW-1:0]   reload_value;
    logic [ByteW-1:0]   interrupt_mask;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] counter;
    logic [ByteW-1:0] divider;
    logic             irq;
  } tmr_status_t;

  typedef struct packed {
    logic               take;
    logic [VectorW-1:0] vector;
    logic [ByteW-1:0]   flags;
    logic               master;
  } irq_status_t;

endpackage

>>> sv/tic_timer.sv
// Free-running divider and reload timer; state commits on step, but a period write clears the timer accumulator.
// Depends on tic_pkg.
module tic_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        period_write,
  input  logic [tic_pkg::CyclesW-1:0] cycles,
  input  tic_pkg::cfg_t               cfg,
  output tic_pkg::tmr_status_t        status
);
  import tic_pkg::*;

  logic [DivAccW-1:0] div_accum, div_accum_next, div_sum;
  logic [ByteW-1:0]   divider, divider_next;
  logic [PeriodW-1:0] tmr_accum, tmr_accum_next;
  logic [PeriodW:0]   tmr_sum;
  logic [ByteW-1:0]   counter, counter_next;
  logic               irq;

  always_comb begin
    div_sum        = div_accum + DivAccW'(cycles);
    div_accum_next = div_sum;
    divider_next   = divider;
    if (div_sum >= DivLimit) begin
      div_accum_next = '0;
      divider_next   = divider + 8'd1;
    end

    tmr_sum        = {1'b0, tmr_accum} + (PeriodW+1)'(cycles);
    tmr_accum_next = tmr_accum;
    counter_next   = counter;
    irq            = 1'b0;
    if (cfg.timer_enable) begin
      tmr_accum_next = tmr_sum[PeriodW-1:0];
      if (tmr_sum >= {1'b0, cfg.timer_period}) begin
        tmr_accum_next = '0;
        if (counter == CounterTop) begin
          counter_next = cfg.reload_value;
          irq          = 1'b1;
        end else begin
          counter_next = counter + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_accum <= '0;
      divider   <= '0;
      tmr_accum <= '0;
      counter   <= '0;
    end else begin
      if (step) begin
        div_accum <= div_accum_next;
        divider   <= divider_next;
        counter   <= counter_next;
      end
      if (period_write) begin
        tmr_accum <= '0;
      end else if (step) begin
        tmr_accum <= tmr_accum_next;
      end
    end
  end

  assign status.counter = counter_next;
  assign status.divider = divider_next;
  assign status.irq     = irq;

endmodule

>>> sv/tic_irq.sv
// Delayed master enable, flag register and fixed-priority dispatch.
// Depends on tic_pkg.
module tic_irq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  tic_pkg::in_t              item,
  input  logic                      timer_irq,
  input  logic [tic_pkg::ByteW-1:0] mask,
  output tic_pkg::irq_status_t      status
);
  import tic_pkg::*;

  logic [1:0]       dis_cnt, dis_cnt_next, dis_arm;
  logic [1:0]       en_cnt, en_cnt_next, en_arm;
  logic             master, master_next, master_mid;
  logic [ByteW-1:0] flags, flags_next, flags_mid;
  logic [ServeN-1:0] pending;
  logic [2:0]       sel;
  logic             take;

  always_comb begin
    dis_arm = item.disable_request ? CountdownArm : dis_cnt;
    en_arm  = item.enable_request  ? CountdownArm : en_cnt;
    dis_cnt_next = dis_arm;
    en_cnt_next  = en_arm;
    master_mid   = master;
    if (dis_arm != 2'd0) begin
      dis_cnt_next = dis_arm - 2'd1;
      if (dis_cnt_next == 2'd0) master_mid = 1'b0;
    end
    if (en_arm != 2'd0) begin
      en_cnt_next = en_arm - 2'd1;
      if (en_cnt_next == 2'd0) master_mid = 1'b1;
    end

    flags_mid = flags | item.irq_requests;
    flags_mid[TimerIrqBit] = flags_mid[TimerIrqBit] | timer_irq;

    pending = flags_mid[ServeN-1:0] & mask[ServeN-1:0];
    sel = '0;
    for (int i = ServeN - 1; i >= 0; i--) begin
      if (pending[i]) sel = 3'(i);
    end

    take        = master_mid && (pending != '0);
    flags_next  = flags_mid;
    master_next = master_mid;
    if (take) begin
      flags_next[sel] = 1'b0;
      master_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dis_cnt <= '0;
      en_cnt  <= '0;
      master  <= 1'b0;
      flags   <= '0;
    end else if (step) begin
      dis_cnt <= dis_cnt_next;
      en_cnt  <= en_cnt_next;
      master  <= master_next;
      flags   <= flags_next;
    end
  end

  assign status.take   = take;
  assign status.vector = take ? (VectorBase + {1'b0, sel, 3'b000}) : '0;
  assign status.flags  = flags_next;
  assign status.master = master_next;

endmodule

>>> sv/timer_interrupt_controller_top.sv
// Timer and interrupt controller: one request per executed instruction in,
// one status result out. Takes one request every cycle while the result side
// keeps up; each request is held in an input register, evaluated, then held
// in the result register. State is committed as each request moves from the
// input register to the result register. Configuration writes are always
// ready and should be issued only while the block holds no request. Depends
// on tic_pkg, tic_timer, tic_irq.
module timer_interrupt_controller_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tic_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tic_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tic_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tic_pkg::CfgDataW-1:0] cfg_data
);
  import tic_pkg::*;

  cfg_t        cfg;
  logic        cfg_wr;
  logic        period_write;
  logic        in_vld;
  in_t         in_q;
  logic        advance;
  tmr_status_t tmr;
  irq_status_t irq;

  assign cfg_ready    = 1'b1;
  assign cfg_wr       = cfg_valid && cfg_ready;
  assign period_write = cfg_wr && (cfg_reg_t'(cfg_index) == REG_TIMER_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_enable   <= 1'b0;
      cfg.timer_period   <= PeriodReset;
      cfg.reload_value   <= '0;
      cfg.interrupt_mask <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIMER_ENABLE:   cfg.timer_enable   <= cfg_data[0];
        REG_TIMER_PERIOD:   cfg.timer_period   <= cfg_data[PeriodW-1:0];
        REG_RELOAD_VALUE:   cfg.reload_value   <= cfg_data[ByteW-1:0];
        REG_INTERRUPT_MASK: cfg.interrupt_mask <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  tic_timer u_timer (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .period_write (period_write),
    .cycles       (in_q.cycles),
    .cfg          (cfg),
    .status       (tmr)
  );

  tic_irq u_irq (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_q),
    .timer_irq (tmr.irq),
    .mask      (cfg.interrupt_mask),
    .status    (irq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.take_interrupt  <= irq.take;
      out_data.vector          <= irq.vector;
      out_data.counter_value   <= tmr.counter;
      out_data.divider_value   <= tmr.divider;
      out_data.interrupt_flags <= irq.flags;
      out_data.master_enable   <= irq.master;
    end
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for timer_interrupt_controller_top: a directed pass, then
// random instruction streams under several timer and mask settings, varied idling and
// a long output stall. Depends on tic_pkg and the controller RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tic_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // predicted controller state
  cfg_t ctl;
  logic [DivAccW-1:0] div_acc;
  int unsigned tmr_acc;
  logic [ByteW-1:0] cnt;
  logic [ByteW-1:0] divr;
  logic [ByteW-1:0] flags;
  logic ime;
  logic [1:0] dis_cd;
  logic [1:0] en_cd;

  out_t pending_status [$];
  int mismatch_count;
  int send_idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left;

  timer_interrupt_controller_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One executed instruction: returns the status the controller should report.
  function automatic out_t step_controller(in_t ins);
    out_t res;
    logic [ServeN-1:0] ready;
    res = '0;
    if (ins.disable_request) dis_cd = CountdownArm;
    if (ins.enable_request) en_cd = CountdownArm;
    if (dis_cd != 0) begin
      dis_cd--;
      if (dis_cd == 0) ime = 1'b0;
    end
    if (en_cd != 0) begin
      en_cd--;
      if (en_cd == 0) ime = 1'b1;
    end
    flags |= ins.irq_requests;
    div_acc += DivAccW'(ins.cycles);
    if (div_acc >= DivLimit) begin
      div_acc = '0;
      divr++;
    end
    if (ctl.timer_enable) begin
      tmr_acc += ins.cycles;
      if (tmr_acc >= ctl.timer_period) begin
        tmr_acc = 0;
        if (cnt == CounterTop) begin
          cnt = ctl.reload_value;
          flags[TimerIrqBit] = 1'b1;
        end else begin
          cnt++;
        end
      end
    end
    if (ime) begin
      ready = flags[ServeN-1:0] & ctl.interrupt_mask[ServeN-1:0];
      for (int b = 0; b < ServeN; b++) begin
        if (ready[b]) begin
          res.take_interrupt = 1'b1;
          res.vector = VectorBase + VectorW'(8 * b);
          flags[b] = 1'b0;
          ime = 1'b0;
          break;
        end
      end
    end
    res.counter_value = cnt;
    res.divider_value = divr;
    res.interrupt_flags = flags;
    res.master_enable = ime;
    return res;
  endfunction

  function automatic in_t rand_instr();
    in_t it;
    int pick;
    it.cycles = ($urandom_range(9) == 0) ? 6'd63 : CyclesW'($urandom_range(63));
    it.disable_request = ($urandom_range(99) < 8);
    it.enable_request = ($urandom_range(99) < 25);
    pick = $urandom_range(9);
    if (pick < 5) it.irq_requests = '0;
    else if (pick < 9) it.irq_requests = ByteW'(1 << $urandom_range(7));
    else it.irq_requests = ByteW'($urandom);
    return it;
  endfunction

  task automatic send_instr(in_t ins);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= ins;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(step_controller(ins));
  endtask

  // Sender pauses until every predicted status has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic te, logic [PeriodW-1:0] period, logic [ByteW-1:0] reload,
                            logic [ByteW-1:0] mask);
    logic [CfgDataW-1:0] vals [4];
    cfg_reg_t r;
    vals[REG_TIMER_ENABLE] = CfgDataW'(te);
    vals[REG_TIMER_PERIOD] = period;
    vals[REG_RELOAD_VALUE] = CfgDataW'(reload);
    vals[REG_INTERRUPT_MASK] = CfgDataW'(mask);
    r = r.first();
    repeat (4) begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      case (r)
        REG_TIMER_ENABLE: ctl.timer_enable = vals[r][0];
        REG_TIMER_PERIOD: begin
          ctl.timer_period = vals[r];
          tmr_acc = 0;
        end
        REG_RELOAD_VALUE: ctl.reload_value = vals[r][ByteW-1:0];
        REG_INTERRUPT_MASK: ctl.interrupt_mask = vals[r][ByteW-1:0];
        default: ;
      endcase
      r = r.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) send_instr(rand_instr());
  endtask

  // divider edge, delayed enable/disable, both requests together, every vector,
  // flag bits 5..7 latched but never served, period of zero
  task automatic test_directed_cases();
    in_t script [20];
    script = '{
      in_t'{6'd63, 1'b0, 1'b0, 8'h00}, in_t'{6'd63, 1'b0, 1'b0, 8'h00},
      in_t'{6'd63, 1'b0, 1'b0, 8'h00}, in_t'{6'd63, 1'b0, 1'b0, 8'h00},
      in_t'{6'd3,  1'b0, 1'b0, 8'h00}, in_t'{6'd0,  1'b0, 1'b1, 8'hE0},
      in_t'{6'd0,  1'b0, 1'b0, 8'h00}, in_t'{6'd1,  1'b0, 1'b0, 8'h1F},
      in_t'{6'd0,  1'b0, 1'b1, 8'h00}, in_t'{6'd0,  1'b0, 1'b0, 8'h00},
      in_t'{6'd0,  1'b1, 1'b1, 8'h00}, in_t'{6'd0,  1'b0, 1'b0, 8'h00},
      in_t'{6'd0,  1'b0, 1'b1, 8'h00}, in_t'{6'd0,  1'b1, 1'b0, 8'h00},
      in_t'{6'd0,  1'b0, 1'b1, 8'h00}, in_t'{6'd0,  1'b0, 1'b0, 8'h00},
      in_t'{6'd0,  1'b0, 1'b1, 8'h08}, in_t'{6'd0,  1'b1, 1'b0, 8'h00},
      in_t'{6'd63, 1'b0, 1'b0, 8'hFF}, in_t'{6'd0,  1'b0, 1'b0, 8'h00}
    };
    set_config(1'b1, 11'd0, 8'hF0, 8'hFF);
    foreach (script[i]) send_instr(script[i]);
    wait_drained();
  endtask

  task automatic test_timer_off();
    set_config(1'b0, PeriodReset, 8'h00, 8'hFF);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(120);
    wait_drained();
  endtask

  task automatic test_period_zero_reload();
    set_config(1'b1, 11'd0, 8'hFF, 8'h04);
    send_idle_pct = 55;
    stall_pct = 0;
    run_random(250);
    wait_drained();
  endtask

  task automatic test_period_one();
    set_config(1'b1, 11'd1, 8'hF0, 8'hFF);
    send_idle_pct = 0;
    stall_pct = 55;
    run_random(150);
    wait_drained();
  endtask

  task automatic test_long_period();
    set_config(1'b1, 11'h7FF, 8'h80, 8'h1F);
    send_idle_pct = 19;
    stall_pct = 19;
    run_random(120);
    wait_drained();
  endtask

  task automatic test_masked_off();
    set_config(1'b1, PeriodReset, 8'hF0, 8'h00);
    send_idle_pct = 0;
    stall_pct = 0;
    run_random(120);
    wait_drained();
  endtask

  task automatic test_random_settings();
    int pct [3];
    pct = '{0, 55, 19};
    repeat (3) begin
      set_config(1'($urandom_range(1)), PeriodW'($urandom_range(40)),
                 ByteW'($urandom), ByteW'($urandom));
      send_idle_pct = pct[$urandom_range(2)];
      stall_pct = pct[$urandom_range(2)];
      run_random(80);
      wait_drained();
    end
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_input_stall();
    set_config(1'b1, 11'd2, 8'h10, 8'hFF);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 80;
    run_random(40);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_status
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status, expected none actual %p", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("take_interrupt", want.take_interrupt, out_data.take_interrupt);
        check_field("vector", want.vector, out_data.vector);
        check_field("counter_value", want.counter_value, out_data.counter_value);
        check_field("divider_value", want.divider_value, out_data.divider_value);
        check_field("interrupt_flags", want.interrupt_flags, out_data.interrupt_flags);
        check_field("master_enable", want.master_enable, out_data.master_enable);
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    ctl = '0;
    ctl.timer_period = PeriodReset;
    div_acc = '0;
    tmr_acc = 0;
    cnt = '0;
    divr = '0;
    flags = '0;
    ime = 1'b0;
    dis_cd = '0;
    en_cd = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_timer_off();
    test_period_zero_reload();
    test_period_one();
    test_long_period();
    test_masked_off();
    test_random_settings();
    test_input_stall();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> timer_interrupt_controller_top.f
sv/tic_pkg.sv
sv/tic_timer.sv
sv/tic_irq.sv
sv/timer_interrupt_controller_top.sv
verif/tb_top.sv
